// ===== rtl/core/wmo_pkg.sv =====
`default_nettype none

package wmo_pkg;

  // default sizes of the table and the morph grid
  localparam int WAVES_DEF = 64;
  localparam int GRID_WIDTH_DEF = 8;
  localparam int GRID_HEIGHT_DEF = 8;
  localparam int SAMPLES_PER_WAVE_DEF = 256;

  // output sample format and its saturation limits
  localparam int SAMPLE_BITS = 16;
  localparam int SAMPLE_MAX = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam int SAMPLE_MIN = -SAMPLE_MAX - 1;

  // operand width of the shared multiply and round unit
  localparam int MAC_W = 26;

  // request opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_GEN = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_GAIN = 2'd0;
  localparam logic [1:0] CFG_COEFF = 2'd1;
  localparam logic [1:0] CFG_MODE_XY = 2'd2;
  localparam logic [1:0] CFG_INTERP = 2'd3;

  // rounding shift of the shared unit
  typedef enum logic [1:0] {
    SH_8,
    SH_14,
    SH_16
  } rshift_t;

  // one operation of the shared unit: base + round((target - base) * mult >> sh)
  typedef struct packed {
    logic signed [MAC_W-1:0] base;
    logic signed [MAC_W-1:0] target;
    logic [15:0] mult;
    rshift_t sh;
  } mac_req_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMUL,
    ST_SADD,
    ST_READ,
    ST_RWAIT,
    ST_LMUL,
    ST_LADD,
    ST_GMUL,
    ST_GADD,
    ST_OUT
  } state_t;

  // table of i mod n for i below 256, eight bits per entry
  function automatic logic [2047:0] mod_table(input int unsigned n);
    logic [2047:0] t;
    logic [7:0] r;
    t = '0;
    r = '0;
    for (int i = 0; i < 256; i++) begin
      t[i*8 +: 8] = r;
      r = ((32'(r) + 32'd1) == n) ? 8'h00 : r + 8'h01;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wmo_ram.sv =====
`default_nettype none

module wmo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/wmo_mac.sv =====
`default_nettype none

module wmo_mac (
  input  wire logic                               clk,
  input  wire wmo_pkg::mac_req_t                  req,
  output logic signed [wmo_pkg::MAC_W-1:0]        res
);

  localparam int DW = wmo_pkg::MAC_W + 1;
  localparam int PW = DW + 17;

  logic signed [DW-1:0] diff;
  logic signed [16:0] mult_s;
  logic signed [PW-1:0] prod_q;
  logic signed [wmo_pkg::MAC_W-1:0] base_q;
  wmo_pkg::rshift_t sh_q;
  logic signed [PW-1:0] bias;
  logic signed [PW-1:0] rnd;
  logic signed [PW-1:0] shd;

  // difference times factor
  assign diff = DW'(req.target) - DW'(req.base);
  assign mult_s = {1'b0, req.mult};

  // product register
  always_ff @(posedge clk) begin
    prod_q <= diff * mult_s;
    base_q <= req.base;
    sh_q <= req.sh;
  end

  // round half up and shift
  always_comb begin
    case (sh_q)
      wmo_pkg::SH_8: begin
        bias = PW'(128);
        rnd = prod_q + bias;
        shd = rnd >>> 8;
      end
      wmo_pkg::SH_14: begin
        bias = PW'(8192);
        rnd = prod_q + bias;
        shd = rnd >>> 14;
      end
      default: begin
        bias = PW'(32768);
        rnd = prod_q + bias;
        shd = rnd >>> 16;
      end
    endcase
  end

  assign res = base_q + wmo_pkg::MAC_W'(shd);

endmodule

`default_nettype wire

// ===== rtl/core/wavetable_morph_oscillator.sv =====
`default_nettype none

// Wavetable oscillator with morphing between stored waves.
// Input channel (in_valid / in_stall): a write request (opcode 0) stores one
// table sample; a generate request (opcode 1) carries morph targets and
// produces one audio_sample on the output channel (out_valid / out_stall).
// Write requests produce no output.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data); the
// user must write it only while the block is idle, unchecked by the block.
// One multiply-and-round unit and one single-port table memory are shared
// under a sequencer; the block takes one request at a time.
// A generate request runs through the shared unit and the table port in
// order: three coordinate updates (skipped with snapping), two table reads
// in Z mode or four in XY mode, one interpolation in Z mode or three in XY
// mode, then one gain step. The next request is accepted once the result
// has moved into the output register.
// A finished result waits in the output register while out_stall is high;
// the next request is already accepted and worked on meanwhile.
// Reset clears phase, coordinates and control registers to their defaults;
// the table contents stay undefined until written.

module wavetable_morph_oscillator #(
  parameter int WAVES = wmo_pkg::WAVES_DEF,
  parameter int GRID_WIDTH = wmo_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = wmo_pkg::GRID_HEIGHT_DEF,
  parameter int SAMPLES_PER_WAVE = wmo_pkg::SAMPLES_PER_WAVE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               opcode,
  input  wire logic [5:0]         wave_number,
  input  wire logic [7:0]         sample_position,
  input  wire logic signed [15:0] sample_value,
  input  wire logic [10:0]        target_x,
  input  wire logic [10:0]        target_y,
  input  wire logic [13:0]        target_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      audio_sample
);

  localparam int XI = $clog2(GRID_WIDTH);
  localparam int YI = $clog2(GRID_HEIGHT);
  localparam int WAVE_W = $clog2(WAVES);
  localparam int XW = XI + 16;
  localparam int YW = YI + 16;
  localparam int ZW = WAVE_W + 16;
  localparam int XT = XI + 8;
  localparam int YT = YI + 8;
  localparam int ZT = WAVE_W + 8;
  localparam int PH_W = $clog2(SAMPLES_PER_WAVE);
  localparam int DEPTH = WAVES * SAMPLES_PER_WAVE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LIM_X = (GRID_WIDTH - 1) * 256;
  localparam int LIM_Y = (GRID_HEIGHT - 1) * 256;
  localparam int LIM_Z = (WAVES - 1) * 256;
  localparam int SX_MAX = (GRID_WIDTH - 1) * 65536;
  localparam int SZ_MAX = (WAVES - 1) * 65536;
  localparam logic [2047:0] WAVE_MOD = wmo_pkg::mod_table(WAVES);

  wmo_pkg::state_t state;
  wmo_pkg::state_t state_next;
  logic [1:0] step;
  logic [1:0] step_next;
  logic [1:0] rd_last;
  logic [1:0] op_last;

  logic [15:0] gain;
  logic [15:0] coeff;
  logic mode_xy;
  logic interp_on;

  logic [XT-1:0] tx;
  logic [YT-1:0] ty;
  logic [ZT-1:0] tz;
  logic [XW-1:0] sx;
  logic [YW-1:0] sy;
  logic [ZW-1:0] sz;
  logic [PH_W-1:0] phase;

  logic signed [15:0] samp [4];
  logic cap_valid;
  logic [1:0] cap_idx;
  logic signed [15:0] lrp0;
  logic signed [15:0] lrp1;
  logic signed [wmo_pkg::MAC_W-1:0] gres;

  logic in_acc;
  logic gen_acc;
  logic out_free;
  logic wr_in_range;

  logic [15:0] tx16;
  logic [15:0] ty16;
  logic [15:0] tz16;
  logic [XT-1:0] tx_cl;
  logic [YT-1:0] ty_cl;
  logic [ZT-1:0] tz_cl;
  logic [XT:0] tx_sum;
  logic [YT:0] ty_sum;
  logic [ZT:0] tz_sum;
  logic [XW-1:0] sx_snap;
  logic [YW-1:0] sy_snap;
  logic [ZW-1:0] sz_snap;

  logic [XI-1:0] xi;
  logic [XI-1:0] xn;
  logic [YI-1:0] yi;
  logic [YI-1:0] yn;
  logic [WAVE_W-1:0] zi;
  logic [WAVE_W-1:0] zn;
  logic [XI-1:0] col_sel;
  logic [YI-1:0] row_sel;
  logic [7:0] grid_idx;
  logic [WAVE_W-1:0] wave_rd;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;

  logic ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [15:0] ram_rdata;

  wmo_pkg::mac_req_t mac_req;
  logic signed [wmo_pkg::MAC_W-1:0] mac_res;
  logic signed [15:0] sat_val;

  // handshakes
  assign in_stall = (state != wmo_pkg::ST_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign gen_acc = in_acc && (opcode == wmo_pkg::OP_GEN);
  assign out_free = !out_valid || !out_stall;
  assign rd_last = mode_xy ? 2'd3 : 2'd1;
  assign op_last = mode_xy ? 2'd2 : 2'd0;

  // target clamping and snapping
  assign tx16 = 16'(target_x);
  assign ty16 = 16'(target_y);
  assign tz16 = 16'(target_z);
  assign tx_cl = XT'((tx16 > 16'(LIM_X)) ? 16'(LIM_X) : tx16);
  assign ty_cl = YT'((ty16 > 16'(LIM_Y)) ? 16'(LIM_Y) : ty16);
  assign tz_cl = ZT'((tz16 > 16'(LIM_Z)) ? 16'(LIM_Z) : tz16);
  assign tx_sum = (XT + 1)'(tx_cl) + (XT + 1)'(128);
  assign ty_sum = (YT + 1)'(ty_cl) + (YT + 1)'(128);
  assign tz_sum = (ZT + 1)'(tz_cl) + (ZT + 1)'(128);
  assign sx_snap = XW'({tx_sum[XT:8], 16'h0000});
  assign sy_snap = YW'({ty_sum[YT:8], 16'h0000});
  assign sz_snap = ZW'({tz_sum[ZT:8], 16'h0000});

  // neighbor waves, wrapping at the grid and bank edges
  assign xi = sx[XW-1:16];
  assign yi = sy[YW-1:16];
  assign zi = sz[ZW-1:16];
  assign xn = (32'(xi) == GRID_WIDTH - 1) ? '0 : xi + XI'(1);
  assign yn = (32'(yi) == GRID_HEIGHT - 1) ? '0 : yi + YI'(1);
  assign zn = (32'(zi) == WAVES - 1) ? '0 : zi + WAVE_W'(1);

  // corner chosen by the read counter
  always_comb begin
    case (step)
      2'd0: begin
        row_sel = yi;
        col_sel = xi;
      end
      2'd1: begin
        row_sel = yi;
        col_sel = xn;
      end
      2'd2: begin
        row_sel = yn;
        col_sel = xi;
      end
      default: begin
        row_sel = yn;
        col_sel = xn;
      end
    endcase
  end

  // table addresses
  assign grid_idx = 8'(row_sel) * 8'(GRID_WIDTH) + 8'(col_sel);
  assign wave_rd = mode_xy ? WAVE_W'(WAVE_MOD[{grid_idx, 3'b000} +: 8])
                           : (step[0] ? zn : zi);
  assign rd_addr = ADDR_W'(wave_rd) * ADDR_W'(SAMPLES_PER_WAVE) + ADDR_W'(phase);
  assign wr_addr = ADDR_W'(wave_number) * ADDR_W'(SAMPLES_PER_WAVE)
                 + ADDR_W'(sample_position);
  assign wr_in_range = (9'(wave_number) < 9'(WAVES))
                    && (13'(sample_position) < 13'(SAMPLES_PER_WAVE));

  // next state
  always_comb begin
    state_next = state;
    step_next = step;
    case (state)
      wmo_pkg::ST_IDLE: begin
        step_next = 2'd0;
        if (gen_acc) begin
          state_next = interp_on ? wmo_pkg::ST_SMUL : wmo_pkg::ST_READ;
        end
      end
      wmo_pkg::ST_SMUL: state_next = wmo_pkg::ST_SADD;
      wmo_pkg::ST_SADD: begin
        if (step == 2'd2) begin
          step_next = 2'd0;
          state_next = wmo_pkg::ST_READ;
        end else begin
          step_next = step + 2'd1;
          state_next = wmo_pkg::ST_SMUL;
        end
      end
      wmo_pkg::ST_READ: begin
        if (step == rd_last) begin
          step_next = 2'd0;
          state_next = wmo_pkg::ST_RWAIT;
        end else begin
          step_next = step + 2'd1;
        end
      end
      wmo_pkg::ST_RWAIT: state_next = wmo_pkg::ST_LMUL;
      wmo_pkg::ST_LMUL: state_next = wmo_pkg::ST_LADD;
      wmo_pkg::ST_LADD: begin
        if (step == op_last) begin
          step_next = 2'd0;
          state_next = wmo_pkg::ST_GMUL;
        end else begin
          step_next = step + 2'd1;
          state_next = wmo_pkg::ST_LMUL;
        end
      end
      wmo_pkg::ST_GMUL: state_next = wmo_pkg::ST_GADD;
      wmo_pkg::ST_GADD: state_next = wmo_pkg::ST_OUT;
      wmo_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = wmo_pkg::ST_IDLE;
        end
      end
      default: state_next = wmo_pkg::ST_IDLE;
    endcase
  end

  // state outputs: shared unit operands and table port
  always_comb begin
    mac_req = '0;
    mac_req.sh = wmo_pkg::SH_8;
    ram_we = 1'b0;
    ram_addr = rd_addr;
    case (state)
      wmo_pkg::ST_IDLE: begin
        ram_we = in_acc && (opcode == wmo_pkg::OP_WRITE) && wr_in_range;
        ram_addr = wr_addr;
      end
      wmo_pkg::ST_SMUL: begin
        mac_req.mult = coeff;
        mac_req.sh = wmo_pkg::SH_16;
        case (step)
          2'd0: begin
            mac_req.base = wmo_pkg::MAC_W'(sx);
            mac_req.target = wmo_pkg::MAC_W'({tx, 8'h00});
          end
          2'd1: begin
            mac_req.base = wmo_pkg::MAC_W'(sy);
            mac_req.target = wmo_pkg::MAC_W'({ty, 8'h00});
          end
          default: begin
            mac_req.base = wmo_pkg::MAC_W'(sz);
            mac_req.target = wmo_pkg::MAC_W'({tz, 8'h00});
          end
        endcase
      end
      wmo_pkg::ST_LMUL: begin
        mac_req.sh = wmo_pkg::SH_8;
        case (step)
          2'd0: begin
            mac_req.base = wmo_pkg::MAC_W'(samp[0]);
            mac_req.target = wmo_pkg::MAC_W'(samp[1]);
            mac_req.mult = mode_xy ? 16'(sx[15:8]) : 16'(sz[15:8]);
          end
          2'd1: begin
            mac_req.base = wmo_pkg::MAC_W'(samp[2]);
            mac_req.target = wmo_pkg::MAC_W'(samp[3]);
            mac_req.mult = 16'(sx[15:8]);
          end
          default: begin
            mac_req.base = wmo_pkg::MAC_W'(lrp0);
            mac_req.target = wmo_pkg::MAC_W'(lrp1);
            mac_req.mult = 16'(sy[15:8]);
          end
        endcase
      end
      wmo_pkg::ST_GMUL: begin
        mac_req.target = wmo_pkg::MAC_W'(lrp0);
        mac_req.mult = gain;
        mac_req.sh = wmo_pkg::SH_14;
      end
      default: begin
        mac_req.sh = wmo_pkg::SH_8;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wmo_pkg::ST_IDLE;
      step <= 2'd0;
      cap_valid <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      cap_valid <= (state == wmo_pkg::ST_READ);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= 16'd4112;
      coeff <= 16'd30;
      mode_xy <= 1'b0;
      interp_on <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        wmo_pkg::CFG_GAIN: gain <= cfg_data;
        wmo_pkg::CFG_COEFF: coeff <= cfg_data;
        wmo_pkg::CFG_MODE_XY: mode_xy <= cfg_data[0];
        wmo_pkg::CFG_INTERP: interp_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // morph coordinates and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      sx <= '0;
      sy <= '0;
      sz <= '0;
      phase <= '0;
    end else begin
      if (gen_acc && !interp_on) begin
        sx <= sx_snap;
        sy <= sy_snap;
        sz <= sz_snap;
      end
      if (state == wmo_pkg::ST_SADD) begin
        case (step)
          2'd0: sx <= XW'(mac_res);
          2'd1: sy <= YW'(mac_res);
          default: sz <= ZW'(mac_res);
        endcase
      end
      if (state == wmo_pkg::ST_OUT && out_free) begin
        phase <= (32'(phase) == SAMPLES_PER_WAVE - 1) ? '0 : phase + PH_W'(1);
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (gen_acc) begin
      tx <= tx_cl;
      ty <= ty_cl;
      tz <= tz_cl;
    end
    cap_idx <= step;
    if (cap_valid) begin
      samp[cap_idx] <= ram_rdata;
    end
    if (state == wmo_pkg::ST_LADD) begin
      if (step == 2'd1) begin
        lrp1 <= 16'(mac_res);
      end else begin
        lrp0 <= 16'(mac_res);
      end
    end
    if (state == wmo_pkg::ST_GADD) begin
      gres <= mac_res;
    end
  end

  // saturate to the sample range
  assign sat_val = (gres > wmo_pkg::MAC_W'(wmo_pkg::SAMPLE_MAX)) ? 16'(wmo_pkg::SAMPLE_MAX)
                 : (gres < wmo_pkg::MAC_W'(wmo_pkg::SAMPLE_MIN)) ? 16'(wmo_pkg::SAMPLE_MIN)
                 : 16'(gres);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == wmo_pkg::ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == wmo_pkg::ST_OUT && out_free) begin
      audio_sample <= sat_val;
    end
  end

  wmo_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_table (
    .clk(clk),
    .we(ram_we),
    .addr(ram_addr),
    .wdata(sample_value),
    .rdata(ram_rdata)
  );

  wmo_mac u_mac (
    .clk(clk),
    .req(mac_req),
    .res(mac_res)
  );

  // table is written only between generate requests
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == wmo_pkg::ST_IDLE)
    else $error("table write outside idle");

  // all table reads are captured before interpolation starts
  a_read_done: assert property (@(posedge clk) disable iff (rst)
    state == wmo_pkg::ST_LMUL |-> !cap_valid)
    else $error("table read still in flight at interpolation");

  // a new result appears only from the output step
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == wmo_pkg::ST_OUT)
    else $error("result loaded outside output step");

  // column and bank coordinates stay within the grid and the bank
  a_sx_range: assert property (@(posedge clk) disable iff (rst)
    32'(sx) <= SX_MAX)
    else $error("column coordinate beyond grid");

  a_sz_range: assert property (@(posedge clk) disable iff (rst)
    32'(sz) <= SZ_MAX)
    else $error("bank coordinate beyond last wave");

endmodule

`default_nettype wire

// ===== test/tb_wavetable_morph_oscillator.sv =====
`default_nettype none

module tb_wavetable_morph_oscillator;

  localparam int NWAVES = wmo_pkg::WAVES_DEF;
  localparam int GW = wmo_pkg::GRID_WIDTH_DEF;
  localparam int GH = wmo_pkg::GRID_HEIGHT_DEF;
  localparam int SPW = wmo_pkg::SAMPLES_PER_WAVE_DEF;
  localparam int RUN_ITEMS = 1850;
  localparam int RUN_PHASES = 8;
  localparam int SETTLE = 30;
  localparam int STALL_LIMIT = 2000;

  // one request on the input channel
  typedef struct packed {
    logic        op;
    logic [5:0]  wave;
    logic [7:0]  pos;
    logic [15:0] value;
    logic [10:0] tx;
    logic [10:0] ty;
    logic [13:0] tz;
  } req_t;

  typedef struct packed {
    logic [15:0] gain;
    logic [15:0] coeff;
    logic        xy;
    logic        smooth;
  } osc_cfg_t;

  // morph coordinates, 16 fractional bits
  typedef struct packed {
    logic [18:0] x;
    logic [18:0] y;
    logic [21:0] z;
  } coord_t;

  // table addresses and weights of one interpolation
  typedef struct packed {
    logic [13:0] a00;
    logic [13:0] a01;
    logic [13:0] a10;
    logic [13:0] a11;
    logic [7:0]  fx;
    logic [7:0]  fy;
  } taps_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = wmo_pkg::CFG_GAIN;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = wmo_pkg::OP_WRITE;
  logic [5:0] wave_number = '0;
  logic [7:0] sample_position = '0;
  logic signed [15:0] sample_value = '0;
  logic [10:0] target_x = '0;
  logic [10:0] target_y = '0;
  logic [13:0] target_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] audio_sample;

  wavetable_morph_oscillator i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .wave_number(wave_number),
    .sample_position(sample_position),
    .sample_value(sample_value),
    .target_x(target_x),
    .target_y(target_y),
    .target_z(target_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .audio_sample(audio_sample)
  );

  // predictor state, advanced on accepted requests
  logic signed [15:0] wave_mem [0:NWAVES*SPW-1];
  osc_cfg_t cfg = '{gain: 16'd4112, coeff: 16'd30, xy: 1'b0, smooth: 1'b1};
  coord_t osc_crd = '0;
  logic [7:0] osc_phase = '0;
  logic signed [15:0] audio_due [$];

  // stimulus side: planned state and the entries already loaded
  bit filled [0:NWAVES*SPW-1];
  coord_t plan_crd = '0;
  logic [7:0] plan_phase = '0;
  req_t req_q [$];
  int issued = 0;
  int accepted = 0;
  int mismatches = 0;
  bit calm = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // floor((p + 2^(sh-1)) / 2^sh)
  function automatic longint round_shift(longint p, int sh);
    return (p + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint lerp8(longint a, longint b, longint f);
    return a + round_shift((b - a) * f, 8);
  endfunction

  // clamp the target, then lag toward it or snap to the nearest whole wave
  function automatic logic [21:0] step_axis(logic [21:0] s, logic [13:0] tgt, longint lim,
                                            osc_cfg_t k);
    longint t, d, cur, c;
    cur = s;
    t = tgt;
    c = k.coeff;
    if (t > lim) t = lim;
    if (k.smooth) begin
      d = (t << 8) - cur;
      return 22'(cur + round_shift(d * c, 16));
    end
    return 22'(((t + 128) >>> 8) << 16);
  endfunction

  function automatic coord_t glide(coord_t c, osc_cfg_t k, logic [10:0] tx, logic [10:0] ty,
                                   logic [13:0] tz);
    coord_t n;
    n.x = 19'(step_axis(c.x, tx, longint'(GW - 1) << 8, k));
    n.y = 19'(step_axis(c.y, ty, longint'(GH - 1) << 8, k));
    n.z = step_axis(c.z, tz, longint'(NWAVES - 1) << 8, k);
    return n;
  endfunction

  // neighbors wrap around the grid or the bank
  function automatic taps_t tap_points(coord_t c, logic xy, logic [7:0] pos);
    taps_t t;
    int xi, yi, xn, yn, zi, zn;
    t = '0;
    if (xy) begin
      xi = int'(c.x >> 16) % GW;
      yi = int'(c.y >> 16) % GH;
      xn = (xi + 1) % GW;
      yn = (yi + 1) % GH;
      t.a00 = 14'(((yi * GW + xi) % NWAVES) * SPW + pos);
      t.a01 = 14'(((yi * GW + xn) % NWAVES) * SPW + pos);
      t.a10 = 14'(((yn * GW + xi) % NWAVES) * SPW + pos);
      t.a11 = 14'(((yn * GW + xn) % NWAVES) * SPW + pos);
      t.fx = c.x[15:8];
      t.fy = c.y[15:8];
    end else begin
      zi = int'(c.z >> 16) % NWAVES;
      zn = (zi + 1) % NWAVES;
      t.a00 = 14'(zi * SPW + pos);
      t.a01 = 14'(zn * SPW + pos);
      t.a10 = t.a00;
      t.a11 = t.a01;
      t.fx = c.z[15:8];
    end
    return t;
  endfunction

  // interpolate, apply gain, saturate
  function automatic logic signed [15:0] morph_out(taps_t t, osc_cfg_t k);
    longint a, b, c, d, v, g, y;
    a = wave_mem[t.a00];
    b = wave_mem[t.a01];
    c = wave_mem[t.a10];
    d = wave_mem[t.a11];
    g = k.gain;
    if (k.xy) v = lerp8(lerp8(a, b, t.fx), lerp8(c, d, t.fx), t.fy);
    else v = lerp8(a, b, t.fx);
    y = round_shift(v * g, 14);
    if (y > wmo_pkg::SAMPLE_MAX) y = wmo_pkg::SAMPLE_MAX;
    if (y < wmo_pkg::SAMPLE_MIN) y = wmo_pkg::SAMPLE_MIN;
    return 16'(y);
  endfunction

  // idle lengths: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_target(int top);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return top;
    if (r == 1) return 0;
    return $urandom_range(0, top);
  endfunction

  function automatic req_t junk_req();
    req_t r;
    r.op = wmo_pkg::OP_WRITE;
    r.wave = 6'($urandom);
    r.pos = 8'($urandom);
    r.value = 16'($urandom);
    r.tx = 11'($urandom);
    r.ty = 11'($urandom);
    r.tz = 14'($urandom);
    return r;
  endfunction

  function automatic osc_cfg_t rand_cfg(int i);
    osc_cfg_t k;
    case ($urandom_range(0, 9))
      0: k.gain = 16'd0;
      1: k.gain = 16'hFFFF;
      2: k.gain = 16'd16384;
      default: k.gain = 16'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0: k.coeff = 16'd0;
      1: k.coeff = 16'd32768;
      2: k.coeff = 16'($urandom_range(1, 64));
      default: k.coeff = 16'($urandom_range(0, 32768));
    endcase
    k.xy = (i < 4) ? i[0] : 1'($urandom);
    k.smooth = (i < 4) ? i[1] : 1'($urandom);
    return k;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("%0t: %0s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic queue_write(logic [5:0] w, logic [7:0] p, logic [15:0] v);
    req_t r;
    r = junk_req();
    r.op = wmo_pkg::OP_WRITE;
    r.wave = w;
    r.pos = p;
    r.value = v;
    filled[{w, p}] = 1'b1;
    req_q.push_back(r);
    issued++;
  endtask

  // load a table entry that a coming generate will read
  task automatic fill_tap(logic [13:0] a);
    if (!filled[a]) queue_write(a[13:8], a[7:0], 16'($urandom));
  endtask

  // generate request, preceded by writes of any entry it reads that is not yet loaded
  task automatic queue_gen(logic [10:0] tx, logic [10:0] ty, logic [13:0] tz);
    req_t r;
    taps_t t;
    plan_crd = glide(plan_crd, cfg, tx, ty, tz);
    t = tap_points(plan_crd, cfg.xy, plan_phase);
    fill_tap(t.a00);
    fill_tap(t.a01);
    fill_tap(t.a10);
    fill_tap(t.a11);
    r = junk_req();
    r.op = wmo_pkg::OP_GEN;
    r.tx = tx;
    r.ty = ty;
    r.tz = tz;
    req_q.push_back(r);
    plan_phase++;
    issued++;
  endtask

  // hold the sender until every result is in and the block has settled
  task automatic drain();
    while (accepted != issued || audio_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_config(osc_cfg_t k);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= wmo_pkg::CFG_GAIN;
    cfg_data <= k.gain;
    @(posedge clk);
    cfg_index <= wmo_pkg::CFG_COEFF;
    cfg_data <= k.coeff;
    @(posedge clk);
    cfg_index <= wmo_pkg::CFG_MODE_XY;
    cfg_data <= {15'($urandom), k.xy};
    @(posedge clk);
    cfg_index <= wmo_pkg::CFG_INTERP;
    cfg_data <= {15'($urandom), k.smooth};
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg = k;
  endtask

  // request driver
  always @(posedge clk) begin : drive
    req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (req_q.size() != 0) begin
        nxt = req_q.pop_front();
        in_valid <= 1'b1;
        opcode <= nxt.op;
        wave_number <= nxt.wave;
        sample_position <= nxt.pos;
        sample_value <= nxt.value;
        target_x <= nxt.tx;
        target_y <= nxt.ty;
        target_z <= nxt.tz;
        gap_left <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 2) == 0);
      stall_left <= pick_gap();
    end
  end

  // check results, then predict from accepted requests
  always @(posedge clk) begin : track
    logic signed [15:0] want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (audio_due.size() == 0) begin
          flag_mismatch("audio_sample with no request pending", audio_sample, 0);
        end else begin
          want = audio_due.pop_front();
          if (audio_sample !== want) flag_mismatch("audio_sample", audio_sample, want);
        end
      end
      if (in_valid && !in_stall) begin
        accepted++;
        if (opcode == wmo_pkg::OP_WRITE) begin
          wave_mem[{wave_number, sample_position}] = sample_value;
        end else begin
          osc_crd = glide(osc_crd, cfg, target_x, target_y, target_z);
          audio_due.push_back(morph_out(tap_points(osc_crd, cfg.xy, osc_phase), cfg));
          osc_phase++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
               STALL_LIMIT, audio_due.size());
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int stop_at;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // full gain, fastest lag, z morph: sample and target extremes
    load_config('{gain: 16'hFFFF, coeff: 16'd32768, xy: 1'b0, smooth: 1'b1});
    queue_write(6'd0, 8'd0, 16'h7FFF);
    queue_write(6'd1, 8'd0, 16'h8000);
    queue_write(6'd63, 8'd255, 16'h7FFF);
    queue_write(6'd62, 8'd255, 16'h8000);
    queue_gen(11'd2047, 11'd2047, 14'd16383);
    queue_gen(11'd0, 11'd0, 14'd0);
    queue_gen(11'd1792, 11'd1792, 14'd16128);
    drain();

    // zero gain, no lag, snapped grid morph: rounding at the half step
    load_config('{gain: 16'd0, coeff: 16'd0, xy: 1'b1, smooth: 1'b0});
    queue_gen(11'd2047, 11'd2047, 14'd16383);
    queue_gen(11'd128, 11'd127, 14'd0);
    queue_gen(11'd1791, 11'd1792, 14'd383);
    drain();

    // unity gain, slowest nonzero lag on the grid
    load_config('{gain: 16'd16384, coeff: 16'd1, xy: 1'b1, smooth: 1'b1});
    queue_gen(11'd2047, 11'd0, 14'd0);
    queue_gen(11'd1000, 11'd2047, 14'd5000);

    // random phases, each started from an idle block
    for (int ph = 0; ph < RUN_PHASES; ph++) begin
      drain();
      load_config(rand_cfg(ph));
      calm = (ph == 2 || ph == 5);
      stop_at = issued + RUN_ITEMS / RUN_PHASES;
      while (issued < stop_at) begin
        if ($urandom_range(0, 3) == 0)
          queue_write(6'($urandom), 8'($urandom), 16'($urandom));
        else
          queue_gen(11'(pick_target(2047)), 11'(pick_target(2047)),
                    14'(pick_target(16383)));
      end
    end
    drain();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
